>>> hdl/plti_pkg.sv
// Shared types, widths and codes for the piecewise-linear table interpolator.
`timescale 1ns / 1ps

package plti_pkg;

    localparam int ENERGY_W      = 24;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_IDX_W   = 8;
    localparam int PROD_W        = VALUE_W + ENERGY_W;
    localparam int DEPTH_DEFAULT = 256;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word index, taken from paddr above the byte offset.
    localparam logic REG_LAST_INDEX = 1'b0;

    localparam logic [ENTRY_IDX_W-1:0] LAST_INDEX_RESET = 8'd200;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [ENERGY_W-1:0]    energy;
        logic [VALUE_W-1:0]     value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] interp_value;
        logic               out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [VALUE_W-1:0]  value;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_BND,
        ST_CHK_BND,
        ST_CHK_FIRST,
        ST_SCAN,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

>>> hdl/piecewise_linear_table_interp.sv
// Top level: table storage, query sequencer and APB register for the interpolator.
//
//   channel   direction  handshake        beat
//   s_        in         s_valid/s_ready  in_item_t  (load or query)
//   m_        out        m_valid/m_ready  out_item_t (one per query)
//   apb       in         psel/penable     last_index register at byte address 0
//
// A load is written to the table when accepted and leaves the sequencer idle. A query is
// taken only while idle, and no new item is taken until its result is emitted; it reads
// the bound entry, checks entry 0, scans the table one entry per cycle through the RAM
// read port up to last_index (saturated to TABLE_DEPTH - 1, so at most 255) and, for an
// interpolated result, runs the 56-step serial divider. Reset sets last_index to 200;
// table contents are undefined until loaded. A stalled m_ side holds the sequencer only at its final step.
`timescale 1ns / 1ps

module piecewise_linear_table_interp
    import plti_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = $bits(entry_t);

    state_t                 state_reg, state_next;
    logic [ENTRY_IDX_W-1:0] last_index_reg;
    logic [ENERGY_W-1:0]    e_reg, e_next;
    logic [IDX_W-1:0]       bnd_reg, bnd_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    entry_t                 prev_reg, prev_next;
    entry_t                 up_reg, up_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [ENERGY_W-1:0]    dv_reg, dv_next;
    logic                   inc_reg, inc_next;
    logic [VALUE_W-1:0]     res_reg, res_next;
    logic                   oor_reg, oor_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic                   s_fire;
    logic                   load_we;
    logic [IDX_W-1:0]       bnd_sat;
    logic [IDX_W-1:0]       raddr;
    logic [ENTRY_W-1:0]     rdata;
    entry_t                 rd_entry;
    logic                   div_start;
    logic                   div_done;
    logic [PROD_W-1:0]      div_q;
    logic [VALUE_W-1:0]     span;
    logic [ENERGY_W-1:0]    de;
    logic                   cfg_wr;
    logic                   cfg_sel_last;

    // ---------------- APB register ----------------
    assign pready       = 1'b1;
    assign cfg_sel_last = (paddr[APB_ADDR_W-1:2] == REG_LAST_INDEX);
    assign cfg_wr       = psel && penable && pwrite && pready && cfg_sel_last;
    assign prdata       = cfg_sel_last ? {{(APB_DATA_W-ENTRY_IDX_W){1'b0}}, last_index_reg}
                                       : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_index_reg <= LAST_INDEX_RESET;
        end else if (cfg_wr) begin
            last_index_reg <= pwdata[ENTRY_IDX_W-1:0];
        end
    end

    // ---------------- table storage ----------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign load_we = s_fire && (s_data.mode == MODE_LOAD) &&
                     (32'(s_data.entry_index) < 32'(TABLE_DEPTH));

    plti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (IDX_W'(s_data.entry_index)),
        .wdata ({s_data.energy, s_data.value}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = rdata;

    // ---------------- serial divider ----------------
    assign div_start = (state_reg == ST_DIV_GO);

    plti_div #(
        .NUM_W (PROD_W),
        .DEN_W (ENERGY_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- sequencer ----------------
    assign bnd_sat = (32'(last_index_reg) > 32'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                                   : IDX_W'(last_index_reg);

    always_comb begin
        unique case (state_reg)
            ST_RD_BND:    raddr = bnd_reg;
            ST_CHK_BND:   raddr = '0;
            ST_CHK_FIRST: raddr = IDX_W'(1);
            ST_SCAN:      raddr = idx_reg + 1'b1;
            default:      raddr = '0;
        endcase
    end

    assign span = (up_reg.value >= prev_reg.value) ? (up_reg.value - prev_reg.value)
                                                   : (prev_reg.value - up_reg.value);
    assign de   = e_reg - prev_reg.energy;

    always_comb begin
        state_next   = state_reg;
        e_next       = e_reg;
        bnd_next     = bnd_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        up_next      = up_reg;
        prod_next    = prod_reg;
        dv_next      = dv_reg;
        inc_next     = inc_reg;
        res_next     = res_reg;
        oor_next     = oor_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.mode == MODE_QUERY)) begin
                    e_next     = s_data.energy;
                    bnd_next   = bnd_sat;
                    state_next = ST_RD_BND;
                end
            end
            ST_RD_BND: begin
                state_next = ST_CHK_BND;
            end
            ST_CHK_BND: begin
                if ((e_reg == '0) || (e_reg >= rd_entry.energy)) begin
                    res_next   = '0;
                    oor_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_CHK_FIRST;
                end
            end
            ST_CHK_FIRST: begin
                oor_next = 1'b0;
                if (rd_entry.energy >= e_reg) begin
                    res_next   = rd_entry.value;
                    state_next = ST_EMIT;
                end else begin
                    prev_next  = rd_entry;
                    idx_next   = IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_entry holds entry idx_reg; the next address is already out
                if (rd_entry.energy == e_reg) begin
                    res_next   = rd_entry.value;
                    state_next = ST_EMIT;
                end else if ((idx_reg == bnd_reg) || (rd_entry.energy > e_reg)) begin
                    up_next    = rd_entry;
                    state_next = ST_MUL;
                end else begin
                    prev_next = rd_entry;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(span) * PROD_W'(de);
                dv_next    = up_reg.energy - prev_reg.energy;
                inc_next   = (up_reg.value >= prev_reg.value);
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    res_next   = inc_reg ? (prev_reg.value + div_q[VALUE_W-1:0])
                                         : (prev_reg.value - div_q[VALUE_W-1:0]);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.interp_value = res_reg;
                    m_data_next.out_of_range = oor_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        e_reg      <= e_next;
        bnd_reg    <= bnd_next;
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        up_reg     <= up_next;
        prod_reg   <= prod_next;
        dv_reg     <= dv_next;
        inc_reg    <= inc_next;
        res_reg    <= res_next;
        oor_reg    <= oor_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside the emit step");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished while the sequencer was not waiting");

    a_scan_within_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= bnd_reg))
        else $error("table scan ran past the bound entry");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_range) |-> (m_data.interp_value == '0))
        else $error("out-of-range result carries a nonzero value");

endmodule

>>> hdl/plti_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/plti_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module plti_div
    import plti_pkg::*;
#(
    parameter int NUM_W = PROD_W,
    parameter int DEN_W = ENERGY_W,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    always_comb begin
        trial     = {rem_reg, nq_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            nq_next   = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next  = {nq_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

>>> tb/sv/piecewise_linear_table_interp_checker.sv
// Checker: mirrors the interpolation table and register and compares every lookup result.
`timescale 1ns / 1ps

module piecewise_linear_table_interp_checker
    import plti_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    lookups_owed
);

    logic [ENERGY_W-1:0]    energy_copy [DEPTH_DEFAULT];
    logic [VALUE_W-1:0]     value_copy  [DEPTH_DEFAULT];
    logic [ENTRY_IDX_W-1:0] bound_idx;
    out_item_t              pending_lookups [$];

    // Offset is taken as a magnitude so the truncation goes toward zero.
    function automatic logic [VALUE_W-1:0] blend(input logic [VALUE_W-1:0]  lo_v,
                                                 input logic [VALUE_W-1:0]  up_v,
                                                 input logic [ENERGY_W-1:0] e,
                                                 input logic [ENERGY_W-1:0] lo_e,
                                                 input logic [ENERGY_W-1:0] up_e);
        logic [63:0] span;
        logic [63:0] quot;
        span = (up_v >= lo_v) ? 64'(up_v - lo_v) : 64'(lo_v - up_v);
        quot = (span * 64'(e - lo_e)) / 64'(up_e - lo_e);
        if (up_v >= lo_v)
            return lo_v + quot[VALUE_W-1:0];
        return lo_v - quot[VALUE_W-1:0];
    endfunction

    function automatic out_item_t interpolate_query(input logic [ENERGY_W-1:0] e);
        out_item_t              r;
        logic [ENTRY_IDX_W-1:0] i;
        r.interp_value = '0;
        r.out_of_range = 1'b0;
        if (e == '0 || e >= energy_copy[bound_idx]) begin
            r.out_of_range = 1'b1;
        end else if (energy_copy[0] >= e) begin
            r.interp_value = value_copy[0];
        end else begin
            // stop at the first entry not below e, even in an unordered table
            i = ENTRY_IDX_W'(1);
            while (i < bound_idx && energy_copy[i] < e)
                i++;
            if (energy_copy[i] == e)
                r.interp_value = value_copy[i];
            else
                r.interp_value = blend(value_copy[i - 1'b1], value_copy[i], e,
                                       energy_copy[i - 1'b1], energy_copy[i]);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            foreach (energy_copy[k]) begin
                energy_copy[k] = '0;
                value_copy[k]  = '0;
            end
            bound_idx = LAST_INDEX_RESET;
            pending_lookups.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_LAST_INDEX)
                bound_idx = pwdata[ENTRY_IDX_W-1:0];

            if (m_valid && m_ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result beat with no lookup pending: interp_value %0h out_of_range %0b",
                           m_data.interp_value, m_data.out_of_range);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_data.interp_value !== want.interp_value) begin
                        $error("interp_value: expected %0h, actual %0h",
                               want.interp_value, m_data.interp_value);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_data.out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               want.out_of_range, m_data.out_of_range);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_QUERY) begin
                    pending_lookups.push_back(interpolate_query(s_data.energy));
                end else begin
                    energy_copy[s_data.entry_index] = s_data.energy;
                    value_copy[s_data.entry_index]  = s_data.value;
                end
            end
        end
        lookups_owed <= pending_lookups.size();
    end

endmodule

>>> tb/sv/piecewise_linear_table_interp_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the table interpolator.
`timescale 1ns / 1ps

module piecewise_linear_table_interp_tb;
    import plti_pkg::*;

    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_CYCLES     = 3000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 206;
    localparam int PHASES          = 5;

    localparam logic [APB_ADDR_W-1:0] LAST_INDEX_ADDR = {REG_LAST_INDEX, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR      = {~REG_LAST_INDEX, 2'b00};

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int lookups_owed;
    int cycle_count   = 0;
    int send_idle_pct = 30;
    int recv_idle_pct = 45;
    bit hold_request  = 1'b0;

    logic [ENERGY_W-1:0]    energy_shadow [DEPTH_DEFAULT];
    logic [ENTRY_IDX_W-1:0] bound_shadow = LAST_INDEX_RESET;

    always #2 aclk = ~aclk;

    piecewise_linear_table_interp uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    piecewise_linear_table_interp_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .lookups_owed   (lookups_owed)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random backpressure, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [VALUE_W-1:0] random_word();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return $urandom();
    endfunction

    // Mostly near breakpoints or inside the live range; some zero and wild energies.
    function automatic logic [ENERGY_W-1:0] pick_query_energy();
        int unsigned         r;
        int unsigned         k;
        logic [ENERGY_W-1:0] top_e;
        r     = $urandom_range(99);
        top_e = energy_shadow[bound_shadow];
        if (r < 8)
            return '0;
        if (r < 18)
            return ENERGY_W'($urandom());
        if (r < 55) begin
            k = $urandom_range(bound_shadow, 0);
            return energy_shadow[ENTRY_IDX_W'(k)] + ENERGY_W'($urandom_range(2, 0))
                   - ENERGY_W'(1);
        end
        if (top_e < 2)
            return ENERGY_W'(1);
        return ENERGY_W'($urandom_range(top_e - 1, 1));
    endfunction

    // Hold valid high across back-to-back beats; drop it only for an idle gap.
    task automatic push_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_entry(input int idx, input logic [ENERGY_W-1:0] e,
                              input logic [VALUE_W-1:0] v);
        in_item_t it;
        it.mode        = MODE_LOAD;
        it.entry_index = ENTRY_IDX_W'(idx);
        it.energy      = e;
        it.value       = v;
        energy_shadow[ENTRY_IDX_W'(idx)] = e;
        push_item(it);
    endtask

    task automatic run_query(input logic [ENERGY_W-1:0] e);
        in_item_t it;
        it.mode        = MODE_QUERY;
        it.entry_index = ENTRY_IDX_W'($urandom());
        it.energy      = e;
        it.value       = $urandom();
        push_item(it);
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lookups_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bound(input logic [ENTRY_IDX_W-1:0] b);
        wait_for_idle();
        apb_write(LAST_INDEX_ADDR, {(APB_DATA_W - ENTRY_IDX_W)'($urandom()), b});
        bound_shadow = b;
    endtask

    initial begin
        int unsigned         e_run;
        int unsigned         r;
        int                  idx;
        int                  lo_e;
        int                  hi_e;
        logic [ENERGY_W-1:0] saved_energy;
        logic [ENTRY_IDX_W-1:0] phase_bound;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unknown register: must leave the bound alone
        apb_write(SPARE_ADDR, $urandom());
        set_bound(LAST_INDEX_RESET);

        // fill every entry with ascending breakpoints so no query reads an unwritten slot
        e_run = $urandom_range(300, 2);
        for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            load_entry(i, ENERGY_W'(e_run), random_word());
            e_run += ($urandom_range(9) == 0) ? 1 : $urandom_range(65000, 1);
        end

        // directed: value extremes on rising and falling segments
        load_entry(10, energy_shadow[10], '0);
        load_entry(11, energy_shadow[11], '1);
        load_entry(12, energy_shadow[12], '0);
        run_query('0);
        run_query('1);
        run_query(energy_shadow[0]);
        run_query(ENERGY_W'(1));
        run_query(energy_shadow[11]);
        run_query(energy_shadow[10] + ((energy_shadow[11] - energy_shadow[10]) >> 1));
        run_query(energy_shadow[11] + ENERGY_W'(1));
        run_query(energy_shadow[12] - ENERGY_W'(1));
        run_query(energy_shadow[bound_shadow]);
        run_query(energy_shadow[bound_shadow] - ENERGY_W'(1));
        run_query(energy_shadow[1]);

        // out-of-order entry: the search runs past it and spans a wide gap
        saved_energy = energy_shadow[30];
        load_entry(30, energy_shadow[20], random_word());
        run_query(energy_shadow[29] + ENERGY_W'(1));
        run_query(energy_shadow[25] + ENERGY_W'(1));
        load_entry(30, saved_energy, random_word());

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: phase_bound = LAST_INDEX_RESET;
                1: phase_bound = '0;
                2: phase_bound = '1;
                3: phase_bound = ENTRY_IDX_W'(37);
                default: phase_bound = ENTRY_IDX_W'(131);
            endcase
            set_bound(phase_bound);
            if (p == 2) begin
                send_idle_pct = 45;
                recv_idle_pct = 30;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 1)
                hold_request = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    run_query(pick_query_energy());
                end else if (r < 95) begin
                    // rewrite an entry while keeping the breakpoints in order
                    idx  = $urandom_range(DEPTH_DEFAULT - 1, 0);
                    lo_e = (idx == 0) ? 1 : int'(energy_shadow[ENTRY_IDX_W'(idx - 1)]) + 1;
                    hi_e = (idx == DEPTH_DEFAULT - 1) ? int'({ENERGY_W{1'b1}})
                                                      : int'(energy_shadow[ENTRY_IDX_W'(idx + 1)])
                                                        - 1;
                    if (lo_e <= hi_e)
                        load_entry(idx, ENERGY_W'($urandom_range(hi_e, lo_e)), random_word());
                    else
                        load_entry(idx, energy_shadow[ENTRY_IDX_W'(idx)], random_word());
                end else begin
                    load_entry($urandom_range(DEPTH_DEFAULT - 1, 0), ENERGY_W'($urandom()),
                               random_word());
                end
            end
        end

        wait_for_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
